// ===== design/tridiagonal_matrix_product_core_macros.svh =====
// ---------------------------------------------------------------------------
// Tridiagonal matrix product core: assertion macros
// Concurrent checks on clk with the synchronous reset masking them.
// ---------------------------------------------------------------------------
`ifndef TRIDIAGONAL_MATRIX_PRODUCT_CORE_MACROS_SVH
`define TRIDIAGONAL_MATRIX_PRODUCT_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property holds at every edge outside reset
`define TMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
// consequence follows the cause (non-overlapping implication)
`define TMP_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error(msg);
`else
`define TMP_ASSERT(lbl, prop, msg)
`define TMP_ASSERT_NEXT(lbl, cause, effect, msg)
`endif

`endif

// ===== design/tmp_pkg.sv =====
// ---------------------------------------------------------------------------
// Tridiagonal matrix product package
// Default widths and the row tag that travels with each band row.
// ---------------------------------------------------------------------------
package tmp_pkg;

  localparam int TMP_WORD_WIDTH = 32;
  localparam int TMP_FRAC_BITS  = 16;
  localparam int TMP_ROW_W      = 16;
  localparam int TMP_SIZE_W     = 16;

  typedef struct packed {
    logic [TMP_ROW_W-1:0] row;
    logic                 last_run;
    logic                 done;
  } tag_t;

endpackage

// ===== design/tridiagonal_matrix_product_core.sv =====
// ---------------------------------------------------------------------------
// Tridiagonal matrix product core
// Streams C = A * B for two n x n tridiagonal matrices given row by row.
// Each input transaction carries row i of A and of B as below, diagonal
// and above band values in signed fixed point (FRAC_BITS fraction bits).
// From row 1 on, every row yields the five band values of product row
// i-1; the last row of a matrix also yields product row n-1, so a last
// row after row zero queues that second band row and holds the input
// until it is sent on. All other rows are taken one per cycle, back to
// back, while out_stall is low. n is registered from cfg_wr_data (0 acts
// as 1). Each band value is rounded half up and saturated; saturated
// flags any clipping in the row. Each result passes through the operand
// register, partial products, exact sums, then round/saturate into the
// output register. The one shared band-row pipeline, fed one operand
// set per cycle while out_stall is low, sets the rate.
// ---------------------------------------------------------------------------
`include "tridiagonal_matrix_product_core_macros.svh"

module tridiagonal_matrix_product_core
  import tmp_pkg::*;
#(
  parameter int WORD_WIDTH = TMP_WORD_WIDTH,
  parameter int FRAC_BITS  = TMP_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [TMP_SIZE_W-1:0]        cfg_wr_data,
  // input rows
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [WORD_WIDTH-1:0] in_a_below,
  input  logic signed [WORD_WIDTH-1:0] in_a_diag,
  input  logic signed [WORD_WIDTH-1:0] in_a_above,
  input  logic signed [WORD_WIDTH-1:0] in_b_below,
  input  logic signed [WORD_WIDTH-1:0] in_b_diag,
  input  logic signed [WORD_WIDTH-1:0] in_b_above,
  // product rows
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [TMP_ROW_W-1:0]         out_row_index,
  output logic signed [WORD_WIDTH-1:0] out_c_minus2,
  output logic signed [WORD_WIDTH-1:0] out_c_minus1,
  output logic signed [WORD_WIDTH-1:0] out_c_center,
  output logic signed [WORD_WIDTH-1:0] out_c_plus1,
  output logic signed [WORD_WIDTH-1:0] out_c_plus2,
  output logic                         out_saturated,
  output logic                         out_last_of_run,
  output logic                         out_matrix_done
);

  localparam int H  = WORD_WIDTH / 2;
  localparam int LW = WORD_WIDTH + H + 1;       // low partial product
  localparam int HW = 2 * WORD_WIDTH - H;       // high partial product
  localparam int SW = 2 * WORD_WIDTH + 2;       // exact band sum
  localparam int NPROD = 9;
  localparam int NBAND = 5;

  typedef logic signed [WORD_WIDTH-1:0] word_t;

  // -------------------------------------------------------------------------
  // Configuration: matrix size
  // -------------------------------------------------------------------------
  logic [TMP_SIZE_W-1:0] matrix_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_size_r <= TMP_SIZE_W'(1);
    end else if (cfg_wr_en) begin
      matrix_size_r <= cfg_wr_data;
    end
  end

  // -------------------------------------------------------------------------
  // Row history: A row i-1, B rows i-2 and i-1, next row index
  // -------------------------------------------------------------------------
  word_t                prev_a_r  [3];
  word_t                prev_bm_r [3];
  word_t                prev_b0_r [3];
  logic [TMP_ROW_W-1:0] row_count_r;

  // pipeline handshake
  logic op_valid_r, s2_valid_r, s3_valid_r, out_valid_r, pend_valid_r;
  logic op_free, s2_free, s3_free, out_free;
  logic in_acc;

  logic [TMP_SIZE_W-1:0] size_eff;
  logic                  last_row;
  logic                  emit_prev;
  word_t                 ca [3];
  word_t                 cb [3];

  always_comb begin
    size_eff  = (matrix_size_r == '0) ? TMP_SIZE_W'(1) : matrix_size_r;
    last_row  = ({1'b0, row_count_r} + (TMP_ROW_W+1)'(1)) >= {1'b0, size_eff};
    emit_prev = (row_count_r != '0);
    // drop band terms that fall outside the matrix
    ca[0] = emit_prev ? in_a_below : '0;
    ca[1] = in_a_diag;
    ca[2] = last_row ? '0 : in_a_above;
    cb[0] = emit_prev ? in_b_below : '0;
    cb[1] = in_b_diag;
    cb[2] = last_row ? '0 : in_b_above;
  end

  // hold input while the second row of a matrix end is queued or the operand stage cannot take a row
  assign in_stall = pend_valid_r || !op_free;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
      for (int k = 0; k < 3; k++) begin
        prev_a_r[k]  <= '0;
        prev_bm_r[k] <= '0;
        prev_b0_r[k] <= '0;
      end
    end else if (in_acc) begin
      if (last_row) begin
        // end of matrix: clear history, restart at row zero
        row_count_r <= '0;
        for (int k = 0; k < 3; k++) begin
          prev_a_r[k]  <= '0;
          prev_bm_r[k] <= '0;
          prev_b0_r[k] <= '0;
        end
      end else begin
        row_count_r <= row_count_r + TMP_ROW_W'(1);
        for (int k = 0; k < 3; k++) begin
          prev_a_r[k]  <= ca[k];
          prev_bm_r[k] <= prev_b0_r[k];
          prev_b0_r[k] <= cb[k];
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Operand stage: one band row's A row and three B rows, plus its tag.
  // The previous row's set goes first; the closing row waits in pend.
  // -------------------------------------------------------------------------
  word_t op_a_r  [3];
  word_t op_bm_r [3];
  word_t op_b0_r [3];
  word_t op_bp_r [3];
  tag_t  op_tag_r;

  word_t pend_a_r  [3];
  word_t pend_bm_r [3];
  word_t pend_b0_r [3];
  tag_t  pend_tag_r;

  word_t op_a_nxt  [3];
  word_t op_bm_nxt [3];
  word_t op_b0_nxt [3];
  word_t op_bp_nxt [3];
  tag_t  op_tag_nxt;
  tag_t  prev_tag, close_tag;
  logic  op_load;

  always_comb begin
    prev_tag.row       = row_count_r - TMP_ROW_W'(1);
    prev_tag.last_run  = !last_row;
    prev_tag.done      = 1'b0;
    close_tag.row      = row_count_r;
    close_tag.last_run = 1'b1;
    close_tag.done     = 1'b1;

    for (int k = 0; k < 3; k++) begin
      if (pend_valid_r) begin
        op_a_nxt[k]  = pend_a_r[k];
        op_bm_nxt[k] = pend_bm_r[k];
        op_b0_nxt[k] = pend_b0_r[k];
        op_bp_nxt[k] = '0;
      end else if (emit_prev) begin
        op_a_nxt[k]  = prev_a_r[k];
        op_bm_nxt[k] = prev_bm_r[k];
        op_b0_nxt[k] = prev_b0_r[k];
        op_bp_nxt[k] = cb[k];
      end else begin
        op_a_nxt[k]  = ca[k];
        op_bm_nxt[k] = prev_b0_r[k];
        op_b0_nxt[k] = cb[k];
        op_bp_nxt[k] = '0;
      end
    end

    if (pend_valid_r) begin
      op_tag_nxt = pend_tag_r;
    end else if (emit_prev) begin
      op_tag_nxt = prev_tag;
    end else begin
      op_tag_nxt = close_tag;
    end

    op_load = op_free && (pend_valid_r || (in_acc && (emit_prev || last_row)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (op_free) begin
        op_valid_r <= op_load;
      end
      if (pend_valid_r && op_free) begin
        pend_valid_r <= 1'b0;
      end else if (in_acc && emit_prev && last_row) begin
        pend_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_load) begin
      op_a_r   <= op_a_nxt;
      op_bm_r  <= op_bm_nxt;
      op_b0_r  <= op_b0_nxt;
      op_bp_r  <= op_bp_nxt;
      op_tag_r <= op_tag_nxt;
    end
    if (in_acc && emit_prev && last_row) begin
      pend_a_r   <= ca;
      pend_bm_r  <= prev_b0_r;
      pend_b0_r  <= cb;
      pend_tag_r <= close_tag;
    end
  end

  // -------------------------------------------------------------------------
  // Partial product stage: nine products of the band row
  // -------------------------------------------------------------------------
  word_t                 mul_x [NPROD];
  word_t                 mul_y [NPROD];
  logic signed [LW-1:0]  p_lo  [NPROD];
  logic signed [HW-1:0]  p_hi  [NPROD];
  logic signed [LW-1:0]  s2_lo_r [NPROD];
  logic signed [HW-1:0]  s2_hi_r [NPROD];
  tag_t                  s2_tag_r;

  always_comb begin
    mul_x[0] = op_a_r[0]; mul_y[0] = op_bm_r[0];   // C[r][r-2]
    mul_x[1] = op_a_r[0]; mul_y[1] = op_bm_r[1];   // C[r][r-1]
    mul_x[2] = op_a_r[1]; mul_y[2] = op_b0_r[0];
    mul_x[3] = op_a_r[0]; mul_y[3] = op_bm_r[2];   // C[r][r]
    mul_x[4] = op_a_r[1]; mul_y[4] = op_b0_r[1];
    mul_x[5] = op_a_r[2]; mul_y[5] = op_bp_r[0];
    mul_x[6] = op_a_r[1]; mul_y[6] = op_b0_r[2];   // C[r][r+1]
    mul_x[7] = op_a_r[2]; mul_y[7] = op_bp_r[1];
    mul_x[8] = op_a_r[2]; mul_y[8] = op_bp_r[2];   // C[r][r+2]
  end

  for (genvar g = 0; g < NPROD; g++) begin : g_mul
    tmp_split_mul #(
      .WORD_WIDTH (WORD_WIDTH)
    ) u_mul (
      .a    (mul_x[g]),
      .b    (mul_y[g]),
      .p_lo (p_lo[g]),
      .p_hi (p_hi[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= op_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && op_valid_r) begin
      s2_lo_r  <= p_lo;
      s2_hi_r  <= p_hi;
      s2_tag_r <= op_tag_r;
    end
  end

  // -------------------------------------------------------------------------
  // Sum stage: exact band sums from the partial products
  // -------------------------------------------------------------------------
  logic signed [SW-1:0] prod  [NPROD];
  logic signed [SW-1:0] sum_c [NBAND];
  logic signed [SW-1:0] s3_sum_r [NBAND];
  tag_t                 s3_tag_r;

  always_comb begin
    for (int k = 0; k < NPROD; k++) begin
      prod[k] = (SW'(s2_hi_r[k]) <<< H) + SW'(s2_lo_r[k]);
    end
    sum_c[0] = prod[0];
    sum_c[1] = prod[1] + prod[2];
    sum_c[2] = prod[3] + prod[4] + prod[5];
    sum_c[3] = prod[6] + prod[7];
    sum_c[4] = prod[8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_free) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && s2_valid_r) begin
      s3_sum_r <= sum_c;
      s3_tag_r <= s2_tag_r;
    end
  end

  // -------------------------------------------------------------------------
  // Output stage: round, saturate and register the result transaction
  // -------------------------------------------------------------------------
  word_t                band_val [NBAND];
  logic [NBAND-1:0]     band_clip;
  word_t                out_band_r [NBAND];
  logic                 out_sat_r;
  tag_t                 out_tag_r;

  for (genvar g = 0; g < NBAND; g++) begin : g_rnd
    tmp_round_sat #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_rnd (
      .sum   (s3_sum_r[g]),
      .value (band_val[g]),
      .clip  (band_clip[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s3_valid_r) begin
      out_band_r <= band_val;
      out_sat_r  <= |band_clip;
      out_tag_r  <= s3_tag_r;
    end
  end

  // advance each stage when its successor has room
  assign out_free = !out_valid_r || !out_stall;
  assign s3_free  = !s3_valid_r  || out_free;
  assign s2_free  = !s2_valid_r  || s3_free;
  assign op_free  = !op_valid_r  || s2_free;

  assign out_valid       = out_valid_r;
  assign out_row_index   = out_tag_r.row;
  assign out_c_minus2    = out_band_r[0];
  assign out_c_minus1    = out_band_r[1];
  assign out_c_center    = out_band_r[2];
  assign out_c_plus1     = out_band_r[3];
  assign out_c_plus2     = out_band_r[4];
  assign out_saturated   = out_sat_r;
  assign out_last_of_run = out_tag_r.last_run;
  assign out_matrix_done = out_tag_r.done;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  // a queued closing row always sits behind a full operand stage
  `TMP_ASSERT(a_pend_behind_op, !pend_valid_r || op_valid_r, "pending row without operand row")
  // a closing row after row zero queues its second band row
  `TMP_ASSERT_NEXT(a_close_queues, in_acc && last_row && emit_prev, pend_valid_r, "closing row not queued")
  // the matrix end returns the row counter to zero
  `TMP_ASSERT_NEXT(a_close_restart, in_acc && last_row, row_count_r == '0, "row count not cleared")
  // the last product row is always the last of its transaction's results
  `TMP_ASSERT(a_done_is_last, !(out_valid_r && out_tag_r.done) || out_tag_r.last_run, "done without last_of_run")

endmodule

// ===== design/tmp_split_mul.sv =====
// ---------------------------------------------------------------------------
// Split signed multiplier
// Forms a * b as two partial products over the low and high halves of b.
// ---------------------------------------------------------------------------
module tmp_split_mul
  import tmp_pkg::*;
#(
  parameter int WORD_WIDTH = TMP_WORD_WIDTH
) (
  input  logic signed [WORD_WIDTH-1:0]                  a,
  input  logic signed [WORD_WIDTH-1:0]                  b,
  output logic signed [WORD_WIDTH+WORD_WIDTH/2:0]       p_lo,
  output logic signed [2*WORD_WIDTH-WORD_WIDTH/2-1:0]   p_hi
);

  localparam int H = WORD_WIDTH / 2;

  // low half is unsigned, high half carries the sign
  assign p_lo = a * $signed({1'b0, b[H-1:0]});
  assign p_hi = a * $signed(b[WORD_WIDTH-1:H]);

endmodule

// ===== design/tmp_round_sat.sv =====
// ---------------------------------------------------------------------------
// Round and saturate
// Rounds an exact sum to FRAC_BITS (half up) and clips it to the word.
// ---------------------------------------------------------------------------
module tmp_round_sat
  import tmp_pkg::*;
#(
  parameter int WORD_WIDTH = TMP_WORD_WIDTH,
  parameter int FRAC_BITS  = TMP_FRAC_BITS
) (
  input  logic signed [2*WORD_WIDTH+1:0] sum,
  output logic signed [WORD_WIDTH-1:0]   value,
  output logic                           clip
);

  localparam int SW = 2 * WORD_WIDTH + 2;
  localparam int RW = ((SW > FRAC_BITS + 1) ? SW : FRAC_BITS + 1) + 1;
  localparam logic signed [RW-1:0] HALF = (RW'(1) << FRAC_BITS) >> 1;
  localparam logic signed [WORD_WIDTH-1:0] MAX_VAL = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam logic signed [WORD_WIDTH-1:0] MIN_VAL = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  logic signed [RW-1:0]        rnd;
  logic signed [RW-1:0]        shf;
  logic [RW-WORD_WIDTH:0]      top_bits;
  logic                        fits;

  always_comb begin
    rnd      = RW'(sum) + HALF;
    shf      = rnd >>> FRAC_BITS;
    top_bits = shf[RW-1:WORD_WIDTH-1];
    fits     = (&top_bits) || (~|top_bits);
    clip     = !fits;
    if (fits) begin
      value = shf[WORD_WIDTH-1:0];
    end else if (rnd[RW-1]) begin
      value = MIN_VAL;
    end else begin
      value = MAX_VAL;
    end
  end

endmodule
